@@ design/gwa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwa_pkg
// Shared constants for the gradient-weighted five-tap blend.
// ----------------------------------------------------------------------------
`default_nettype none

package gwa_pkg;

   localparam int AVG_BITS_DEFAULT  = 10;
   localparam int GRAD_BITS_DEFAULT = 12;
   localparam int TAP_COUNT         = 5;

endpackage

`default_nettype wire

@@ design/gwa_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwa_req_if
// Request channel: five directional averages and five gradient weights.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwa_req_if #(
   parameter int AVG_BITS  = gwa_pkg::AVG_BITS_DEFAULT,
   parameter int GRAD_BITS = gwa_pkg::GRAD_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [AVG_BITS-1:0]  center_avg;
   logic [AVG_BITS-1:0]  up_avg;
   logic [AVG_BITS-1:0]  down_avg;
   logic [AVG_BITS-1:0]  left_avg;
   logic [AVG_BITS-1:0]  right_avg;
   logic [GRAD_BITS-1:0] center_grad;
   logic [GRAD_BITS-1:0] up_grad;
   logic [GRAD_BITS-1:0] down_grad;
   logic [GRAD_BITS-1:0] left_grad;
   logic [GRAD_BITS-1:0] right_grad;

   modport source (
      output valid, center_avg, up_avg, down_avg, left_avg, right_avg,
             center_grad, up_grad, down_grad, left_grad, right_grad,
      input  ready
   );

   modport sink (
      input  valid, center_avg, up_avg, down_avg, left_avg, right_avg,
             center_grad, up_grad, down_grad, left_grad, right_grad,
      output ready
   );
endinterface

`default_nettype wire

@@ design/gwa_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwa_rsp_if
// Response channel: one blended value.
// ----------------------------------------------------------------------------
`default_nettype none

interface gwa_rsp_if #(
   parameter int AVG_BITS = gwa_pkg::AVG_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [AVG_BITS-1:0] blended;

   modport source (
      output valid, blended,
      input  ready
   );

   modport sink (
      input  valid, blended,
      output ready
   );
endinterface

`default_nettype wire

@@ design/gradient_weighted_average_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_weighted_average_unit
// Blends five directional averages by their gradient weights:
// sum(avg*grad) / sum(grad), or the plain mean of the averages when all
// gradients are zero.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    five *_avg, five *_grad
//   rsp_ch    out   valid/ready    blended
//
// One request enters per cycle while no finished response is waiting. The
// pipeline holds products, weighted sum, one divider stage per quotient bit
// and an output register. The divider pipeline sets the depth.
// Synchronous reset clears the valid bits only.
// A stalled response freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_weighted_average_unit #(
   parameter int AVG_BITS  = gwa_pkg::AVG_BITS_DEFAULT,
   parameter int GRAD_BITS = gwa_pkg::GRAD_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   gwa_req_if.sink    req_ch,
   gwa_rsp_if.source  rsp_ch
);

   import gwa_pkg::*;

   localparam int SUM_EXT       = $clog2(TAP_COUNT);
   localparam int PROD_BITS     = AVG_BITS + GRAD_BITS;
   localparam int ASUM_BITS     = AVG_BITS + SUM_EXT;
   localparam int DIVISOR_BITS  = GRAD_BITS + SUM_EXT;
   localparam int DIVIDEND_BITS = DIVISOR_BITS + AVG_BITS;

   logic                     en;
   logic [AVG_BITS-1:0]      avg  [TAP_COUNT];
   logic [GRAD_BITS-1:0]     grad [TAP_COUNT];

   logic [PROD_BITS-1:0]     prod_in      [TAP_COUNT];
   logic [PROD_BITS-1:0]     prod_ff      [TAP_COUNT];
   logic [ASUM_BITS-1:0]     avg_sum_in;
   logic [ASUM_BITS-1:0]     avg_sum_ff;
   logic [DIVISOR_BITS-1:0]  gtotal_in;
   logic [DIVISOR_BITS-1:0]  gtotal_ff;
   logic                     s1_valid_ff;

   logic [DIVIDEND_BITS-1:0] wsum;
   logic [DIVIDEND_BITS-1:0] dividend_in;
   logic [DIVIDEND_BITS-1:0] dividend_ff;
   logic [DIVISOR_BITS-1:0]  divisor_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff;
   logic                     s2_valid_ff;

   logic                     div_valid;
   logic [AVG_BITS-1:0]      div_quot;
   logic [AVG_BITS-1:0]      blended_ff;
   logic                     rsp_valid_ff;

   // advance everything unless a finished response is waiting
   assign en           = ~rsp_valid_ff | rsp_ch.ready;
   assign req_ch.ready = en;

   assign avg[0]  = req_ch.center_avg;
   assign avg[1]  = req_ch.up_avg;
   assign avg[2]  = req_ch.down_avg;
   assign avg[3]  = req_ch.left_avg;
   assign avg[4]  = req_ch.right_avg;
   assign grad[0] = req_ch.center_grad;
   assign grad[1] = req_ch.up_grad;
   assign grad[2] = req_ch.down_grad;
   assign grad[3] = req_ch.left_grad;
   assign grad[4] = req_ch.right_grad;

   always_comb begin
      avg_sum_in = '0;
      gtotal_in  = '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
         prod_in[k] = PROD_BITS'(avg[k]) * PROD_BITS'(grad[k]);
         avg_sum_in = avg_sum_in + ASUM_BITS'(avg[k]);
         gtotal_in  = gtotal_in + DIVISOR_BITS'(grad[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         avg_sum_ff <= avg_sum_in;
         gtotal_ff  <= gtotal_in;
      end
   end

   always_comb begin
      wsum = '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
         wsum = wsum + DIVIDEND_BITS'(prod_ff[k]);
      end
      if (gtotal_ff == '0) begin
         dividend_in = DIVIDEND_BITS'(avg_sum_ff);
         divisor_in  = DIVISOR_BITS'(TAP_COUNT);
      end else begin
         dividend_in = wsum;
         divisor_in  = gtotal_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dividend_ff <= dividend_in;
         divisor_ff  <= divisor_in;
      end
   end

   gwa_div #(
      .DIVISOR_BITS (DIVISOR_BITS),
      .QUOT_BITS    (AVG_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .dividend  (dividend_ff),
      .divisor   (divisor_ff),
      .out_valid (div_valid),
      .quotient  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         blended_ff <= div_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= req_ch.valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= div_valid;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.blended = blended_ff;

endmodule

`default_nettype wire

@@ design/gwa_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwa_div
// Pipelined restoring divider, one quotient bit per register stage, MSB
// first. The dividend must be below divisor << QUOT_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module gwa_div #(
   parameter int DIVISOR_BITS = 15,
   parameter int QUOT_BITS    = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire logic [DIVISOR_BITS+QUOT_BITS-1:0] dividend,
   input  wire logic [DIVISOR_BITS-1:0]           divisor,
   output      logic                              out_valid,
   output      logic [QUOT_BITS-1:0]              quotient
);

   localparam int REM_BITS = DIVISOR_BITS + QUOT_BITS;

   logic [REM_BITS-1:0]     rem_ff     [QUOT_BITS];
   logic [DIVISOR_BITS-1:0] divisor_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0]    quot_ff    [QUOT_BITS];
   logic [QUOT_BITS-1:0]    valid_ff;

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
      logic [REM_BITS-1:0]     rem_prev;
      logic [DIVISOR_BITS-1:0] divisor_prev;
      logic [QUOT_BITS-1:0]    quot_prev;
      logic                    valid_prev;
      logic [REM_BITS-1:0]     shifted;
      logic [REM_BITS:0]       diff;
      logic                    fits;
      logic [REM_BITS-1:0]     rem_in;
      logic [QUOT_BITS-1:0]    quot_in;

      if (k == 0) begin : g_first
         assign rem_prev     = dividend;
         assign divisor_prev = divisor;
         assign quot_prev    = '0;
         assign valid_prev   = in_valid;
      end else begin : g_next
         assign rem_prev     = rem_ff[k-1];
         assign divisor_prev = divisor_ff[k-1];
         assign quot_prev    = quot_ff[k-1];
         assign valid_prev   = valid_ff[k-1];
      end

      always_comb begin
         shifted = REM_BITS'(divisor_prev) << (QUOT_BITS - 1 - k);
         diff    = {1'b0, rem_prev} - {1'b0, shifted};
         fits    = ~diff[REM_BITS];
         rem_in  = fits ? diff[REM_BITS-1:0] : rem_prev;
         quot_in = {quot_prev[QUOT_BITS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]     <= rem_in;
            divisor_ff[k] <= divisor_prev;
            quot_ff[k]    <= quot_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_BITS-1];
   assign quotient  = quot_ff[QUOT_BITS-1];

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for gradient_weighted_average_unit. Directed corner pixels and
// random neighborhoods go in on the request channel. A scoreboard predicts
// each blended value and checks the responses in order. Both sides idle at
// random, the receiver holds off long enough to back up the pipeline, and
// the sender pauses once until the pipeline has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int AVG_BITS    = gwa_pkg::AVG_BITS_DEFAULT;
   localparam int GRAD_BITS   = gwa_pkg::GRAD_BITS_DEFAULT;
   localparam int TAPS        = gwa_pkg::TAP_COUNT;
   localparam int LATENCY     = AVG_BITS + 3;
   localparam int RANDOM_REQS = 1250;
   localparam int HOLD_CYCLES = 60;

   // tap order: center, up, down, left, right
   typedef struct {
      logic [AVG_BITS-1:0]  avg  [TAPS];
      logic [GRAD_BITS-1:0] grad [TAPS];
   } pixel_type;

   class blend_scoreboard;
      logic [AVG_BITS-1:0] blend_q[$];
      int                  errors;

      function new();
         errors = 0;
      endfunction

      static function logic [AVG_BITS-1:0] weighted_blend(pixel_type p);
         longint unsigned avg_sum;
         longint unsigned gtotal;
         longint unsigned wtotal;
         longint unsigned quotient;
         avg_sum = 0;
         gtotal  = 0;
         wtotal  = 0;
         for (int k = 0; k < TAPS; k++) begin
            avg_sum += p.avg[k];
            gtotal  += p.grad[k];
            wtotal  += longint'(p.avg[k]) * longint'(p.grad[k]);
         end
         if (gtotal == 0) begin
            quotient = avg_sum / TAPS;
         end else begin
            quotient = wtotal / gtotal;
         end
         return quotient[AVG_BITS-1:0];
      endfunction

      function void note_request(pixel_type p);
         blend_q.push_back(weighted_blend(p));
      endfunction

      function void check_response(logic [AVG_BITS-1:0] blended);
         logic [AVG_BITS-1:0] want;
         if (blend_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got blended %0d",
                     $time, blended);
            errors++;
         end else begin
            want = blend_q.pop_front();
            if (blended !== want) begin
               $display("%0t: blended mismatch, expected %0d, got %0d",
                        $time, want, blended);
               errors++;
            end
         end
      endfunction

      function int pending();
         return blend_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   hold_off_requests;
   bit   send_idles;

   gwa_req_if #(.AVG_BITS(AVG_BITS), .GRAD_BITS(GRAD_BITS)) req_if ();
   gwa_rsp_if #(.AVG_BITS(AVG_BITS)) rsp_if ();

   gradient_weighted_average_unit #(
      .AVG_BITS  (AVG_BITS),
      .GRAD_BITS (GRAD_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   blend_scoreboard blend_sb = new();

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic pixel_type taps(int c, int u, int d, int l, int r,
                                      int gc, int gu, int gd, int gl, int gr);
      pixel_type p;
      p.avg[0]  = AVG_BITS'(c);
      p.avg[1]  = AVG_BITS'(u);
      p.avg[2]  = AVG_BITS'(d);
      p.avg[3]  = AVG_BITS'(l);
      p.avg[4]  = AVG_BITS'(r);
      p.grad[0] = GRAD_BITS'(gc);
      p.grad[1] = GRAD_BITS'(gu);
      p.grad[2] = GRAD_BITS'(gd);
      p.grad[3] = GRAD_BITS'(gl);
      p.grad[4] = GRAD_BITS'(gr);
      return p;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      int        kind;
      int        hot;
      kind = $urandom_range(0, 9);
      hot  = $urandom_range(0, TAPS - 1);
      for (int k = 0; k < TAPS; k++) begin
         p.avg[k] = AVG_BITS'($urandom);
         case (kind)
            0: p.grad[k] = '0;
            1: p.grad[k] = (k == hot) ? GRAD_BITS'($urandom) : '0;
            2: p.grad[k] = GRAD_BITS'($urandom_range(0, 3));
            3: begin
               case ($urandom_range(0, 2))
                  0: p.avg[k] = '0;
                  1: p.avg[k] = '1;
                  default: p.avg[k] = AVG_BITS'($urandom);
               endcase
               case ($urandom_range(0, 2))
                  0: p.grad[k] = '0;
                  1: p.grad[k] = '1;
                  default: p.grad[k] = GRAD_BITS'($urandom);
               endcase
            end
            default: p.grad[k] = GRAD_BITS'($urandom);
         endcase
      end
      return p;
   endfunction

   task automatic offer(input pixel_type p);
      while (send_idles && $urandom_range(0, 99) < 7) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.center_avg  <= p.avg[0];
      req_if.up_avg      <= p.avg[1];
      req_if.down_avg    <= p.avg[2];
      req_if.left_avg    <= p.avg[3];
      req_if.right_avg   <= p.avg[4];
      req_if.center_grad <= p.grad[0];
      req_if.up_grad     <= p.grad[1];
      req_if.down_grad   <= p.grad[2];
      req_if.left_grad   <= p.grad[3];
      req_if.right_grad  <= p.grad[4];
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      @(posedge clock);
      while (blend_sb.pending() != 0) @(posedge clock);
   endtask

   // note accepted requests, check accepted responses
   always @(posedge clock) begin
      pixel_type p;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            p = taps(req_if.center_avg, req_if.up_avg, req_if.down_avg,
                     req_if.left_avg, req_if.right_avg,
                     req_if.center_grad, req_if.up_grad, req_if.down_grad,
                     req_if.left_grad, req_if.right_grad);
            blend_sb.note_request(p);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            blend_sb.check_response(rsp_if.blended);
         end
      end
   end

   initial begin : receiver
      int cycle     = 0;
      int hold_left = 0;
      int served    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (hold_off_requests > served) begin
            served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (cycle >= 1500 && cycle < 3500) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 7);
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      pixel_type directed_q[$];
      reset             = 1'b1;
      hold_off_requests = 0;
      send_idles        = 1'b1;
      req_if.valid       = 1'b0;
      req_if.center_avg  = '0;
      req_if.up_avg      = '0;
      req_if.down_avg    = '0;
      req_if.left_avg    = '0;
      req_if.right_avg   = '0;
      req_if.center_grad = '0;
      req_if.up_grad     = '0;
      req_if.down_grad   = '0;
      req_if.left_grad   = '0;
      req_if.right_grad  = '0;

      directed_q.push_back(taps(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(taps(1023, 1023, 1023, 1023, 1023, 0, 0, 0, 0, 0));
      directed_q.push_back(taps(1023, 1023, 1023, 1023, 1022, 0, 0, 0, 0, 0));
      directed_q.push_back(taps(1, 1, 1, 1, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(taps(1023, 1023, 1023, 1023, 1023,
                                4095, 4095, 4095, 4095, 4095));
      directed_q.push_back(taps(0, 0, 0, 0, 0, 4095, 4095, 4095, 4095, 4095));
      directed_q.push_back(taps(1023, 1023, 1023, 1023, 0,
                                4095, 4095, 4095, 4095, 4095));
      directed_q.push_back(taps(100, 200, 300, 400, 500, 4095, 0, 0, 0, 0));
      directed_q.push_back(taps(100, 200, 300, 400, 500, 0, 4095, 0, 0, 0));
      directed_q.push_back(taps(100, 200, 300, 400, 500, 0, 0, 4095, 0, 0));
      directed_q.push_back(taps(100, 200, 300, 400, 500, 0, 0, 0, 4095, 0));
      directed_q.push_back(taps(100, 200, 300, 400, 500, 0, 0, 0, 0, 4095));
      directed_q.push_back(taps(7, 1023, 0, 512, 3, 0, 0, 1, 0, 0));
      directed_q.push_back(taps(1, 2, 3, 4, 5, 1, 1, 1, 1, 1));
      directed_q.push_back(taps(0, 1, 0, 1, 0, 1, 4094, 1, 4094, 1));
      directed_q.push_back(taps(1023, 0, 0, 0, 0, 1, 4095, 4095, 4095, 4095));
      directed_q.push_back(taps('h2AA, 'h155, 'h2AA, 'h155, 'h2AA,
                                'hAAA, 'h555, 'hAAA, 'h555, 'hAAA));
      directed_q.push_back(taps('h155, 'h2AA, 'h155, 'h2AA, 'h155,
                                'h555, 'hAAA, 'h555, 'hAAA, 'h555));
      directed_q.push_back(taps(1023, 0, 1023, 0, 1023, 0, 4095, 0, 4095, 0));
      directed_q.push_back(taps(0, 1023, 0, 1023, 0, 1, 0, 0, 0, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i]) offer(directed_q[i]);

      for (int n = 0; n < RANDOM_REQS; n++) begin
         send_idles = !(n >= 400 && n < 700);
         if (n == 200) hold_off_requests++;
         if (n == 900) begin
            req_if.valid <= 1'b0;
            drain();
         end
         offer(random_pixel());
      end
      req_if.valid <= 1'b0;

      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (blend_sb.errors == 0 && blend_sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
